/* sv/adq_pkg.sv */
// ----------------------------------------------------------------------------
// adq_pkg - shared types for the aging double-ended queue
// Command and status codes, and the flag group that the entry store reports.
// ----------------------------------------------------------------------------
package adq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_TICK       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	// occupancy flags of the entry store
	typedef struct packed {
		logic full;
		logic empty;
	} store_flags_t;

endpackage

/* sv/adq_store.sv */
// ----------------------------------------------------------------------------
// adq_store - entry store of the aging double-ended queue
// Entries sit in a shift line with the front at position 0; pushes and pops
// at the front shift the line, rear accesses use the count. Every entry has
// its own saturating wait counter.
// ----------------------------------------------------------------------------
module adq_store #(
	parameter int DEPTH     = 16,
	parameter int WAIT_BITS = 16,
	localparam int CW       = $clog2(DEPTH + 1),
	localparam int IW       = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  adq_pkg::cmd_t         cmd,
	input  logic signed [31:0]    data_value,
	output logic [CW-1:0]         count,
	output adq_pkg::store_flags_t flags,
	output logic signed [31:0]    front_value,
	output logic [WAIT_BITS-1:0]  front_wait,
	output logic signed [31:0]    rear_value,
	output logic [WAIT_BITS-1:0]  rear_wait
);

	logic signed [31:0]   val_q  [DEPTH];
	logic [WAIT_BITS-1:0] wait_q [DEPTH];
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        last;
	logic                 full, empty;
	logic                 do_pf, do_pr, do_qf, do_qr, do_tick;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign do_pf   = upd && (cmd == adq_pkg::CMD_PUSH_FRONT) && !full;
	assign do_pr   = upd && (cmd == adq_pkg::CMD_PUSH_REAR)  && !full;
	assign do_qf   = upd && (cmd == adq_pkg::CMD_POP_FRONT)  && !empty;
	assign do_qr   = upd && (cmd == adq_pkg::CMD_POP_REAR)   && !empty;
	assign do_tick = upd && (cmd == adq_pkg::CMD_TICK);

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_entry
			logic signed [31:0]   val_prev, val_next;
			logic [WAIT_BITS-1:0] wait_prev, wait_next;

			if (i == 0) begin : g_head
				assign val_prev  = data_value;
				assign wait_prev = '0;
			end else begin : g_body
				assign val_prev  = val_q[i-1];
				assign wait_prev = wait_q[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign val_next  = val_q[i];
				assign wait_next = wait_q[i];
			end else begin : g_mid
				assign val_next  = val_q[i+1];
				assign wait_next = wait_q[i+1];
			end

			always_ff @(posedge clk) begin
				if (do_pf) begin
					val_q[i]  <= val_prev;
					wait_q[i] <= wait_prev;
				end else if (do_qf) begin
					val_q[i]  <= val_next;
					wait_q[i] <= wait_next;
				end else if (do_pr && (count_q[IW-1:0] == IW'(i))) begin
					val_q[i]  <= data_value;
					wait_q[i] <= '0;
				end else if (do_tick && (wait_q[i] != '1)) begin
					wait_q[i] <= wait_q[i] + WAIT_BITS'(1);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_pf || do_pr) begin
			count_q <= count_q + CW'(1);
		end else if (do_qf || do_qr) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign last        = count_q - CW'(1);
	assign count       = count_q;
	assign flags.full  = full;
	assign flags.empty = empty;
	assign front_value = empty ? '0 : val_q[0];
	assign front_wait  = empty ? '0 : wait_q[0];
	assign rear_value  = empty ? '0 : val_q[last[IW-1:0]];
	assign rear_wait   = empty ? '0 : wait_q[last[IW-1:0]];

endmodule

/* sv/aging_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// aging_double_ended_queue - bounded deque of signed 32-bit values with ageing
// Push and pop at either end, plus a tick that ages every held entry.
// ----------------------------------------------------------------------------
// One command beat in gives one result beat out, after it has passed stage 1,
// stage 2 and the result register. A new command is taken every cycle: the
// only loop is the update of the entry store and its count, so the
// sustained rate is one beat per cycle while m_tready stays high. A stall on
// the output side freezes the whole pipe, and s_tready drops with it. Holds
// up to DEPTH entries; wait counters are WAIT_BITS wide and saturate. Push
// when full reports overflow, pop when empty reports underflow, and in both
// cases the queue is left as it was. Unknown command codes change nothing and
// report the current contents. A lone entry is both front and rear; an empty
// queue reports zero values and waits. No clearing pass is needed after
// reset: only held entries are ever read.
// ----------------------------------------------------------------------------
module aging_double_ended_queue #(
	parameter int DEPTH     = 16,
	parameter int WAIT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// command side
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // cmd[2:0], data_value[34:3], zero pad
	// result side
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // status[1:0], entry_total[6:2], is_empty[7],
	                                // front_value[39:8], front_wait[55:40],
	                                // rear_value[87:56], rear_wait[103:88]
);

	localparam int CW = $clog2(DEPTH + 1);

	// pipe advances when the result register is free or being drained
	logic                  advance;

	// stage 1: accepted command
	logic                  valid_s1;
	adq_pkg::cmd_t         cmd_s1;
	logic signed [31:0]    data_s1;

	// stage 2: store already updated, status waiting for the report
	logic                  valid_s2;
	adq_pkg::status_t      status_s2;

	// result register
	logic                  m_tvalid_q;
	adq_pkg::status_t      status_q;
	logic [CW-1:0]         total_q;
	logic signed [31:0]    front_value_q, rear_value_q;
	logic [WAIT_BITS-1:0]  front_wait_q, rear_wait_q;

	// store view
	logic                  upd;
	logic [CW-1:0]         count_w;
	adq_pkg::store_flags_t flags_w;
	logic signed [31:0]    front_value_w, rear_value_w;
	logic [WAIT_BITS-1:0]  front_wait_w, rear_wait_w;
	adq_pkg::status_t      status_w;

	// fixed-width views of the result fields
	logic [CW+4:0]         total_ext;
	logic [WAIT_BITS+15:0] front_wait_ext, rear_wait_ext;

	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = advance;
	assign upd      = advance && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			cmd_s1  <= adq_pkg::cmd_t'(s_tdata[2:0]);
			data_s1 <= s_tdata[34:3];
		end
	end

	adq_store #(
		.DEPTH     (DEPTH),
		.WAIT_BITS (WAIT_BITS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.cmd         (cmd_s1),
		.data_value  (data_s1),
		.count       (count_w),
		.flags       (flags_w),
		.front_value (front_value_w),
		.front_wait  (front_wait_w),
		.rear_value  (rear_value_w),
		.rear_wait   (rear_wait_w)
	);

	// status from occupancy before the update
	always_comb begin
		status_w = adq_pkg::ST_OK;
		case (cmd_s1) inside
			adq_pkg::CMD_PUSH_FRONT, adq_pkg::CMD_PUSH_REAR: begin
				if (flags_w.full) status_w = adq_pkg::ST_OVER;
			end
			adq_pkg::CMD_POP_FRONT, adq_pkg::CMD_POP_REAR: begin
				if (flags_w.empty) status_w = adq_pkg::ST_UNDER;
			end
			default: status_w = adq_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			valid_s2   <= valid_s1;
			m_tvalid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			status_s2 <= status_w;
		end
	end

	// the store now shows the state left by the beat in stage 2
	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			status_q      <= status_s2;
			total_q       <= count_w;
			front_value_q <= front_value_w;
			front_wait_q  <= front_wait_w;
			rear_value_q  <= rear_value_w;
			rear_wait_q   <= rear_wait_w;
		end
	end

	assign total_ext      = {5'd0, total_q};
	assign front_wait_ext = {16'd0, front_wait_q};
	assign rear_wait_ext  = {16'd0, rear_wait_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {rear_wait_ext[15:0], rear_value_q,
	                   front_wait_ext[15:0], front_value_q,
	                   (total_q == '0), total_ext[4:0], status_q};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_w <= CW'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && !flags_w.full && (cmd_s1 == adq_pkg::CMD_PUSH_FRONT ||
		 cmd_s1 == adq_pkg::CMD_PUSH_REAR))
		|=> count_w == $past(count_w) + CW'(1))
		else $error("accepted push did not grow the count");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == adq_pkg::ST_OVER) |-> total_q == CW'(DEPTH))
		else $error("overflow reported on a queue that is not full");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == adq_pkg::ST_UNDER) |-> total_q == '0)
		else $error("underflow reported on a queue that is not empty");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the aging double-ended queue
// Walks a short table of directed commands (empty pops, extremes, spare codes,
// fill to full and overflow), then biased random traffic with bursts of idle
// on both stream sides, quiet towards the end. Every result beat is checked
// against an in-bench deque.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH        = 16;
	localparam int RANDOM_BEATS = 1900;
	localparam int QUIET_FROM   = 1500;    // no idling from here on
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SHOW_LIMIT   = 10;

	// command codes the block treats as no-ops
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	// one result beat, laid out as m_tdata (last field in the low bits)
	typedef struct packed {
		logic [15:0]      rear_wait;
		logic [31:0]      rear_value;
		logic [15:0]      front_wait;
		logic [31:0]      front_value;
		logic             is_empty;
		logic [4:0]       entry_total;
		adq_pkg::status_t status;
	} deque_view_t;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] val;
		bit          typed;     // view below is written out by hand
		deque_view_t view;
	} dir_row_t;

	logic          clk;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [39:0]   s_tdata  = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b1;
	logic [103:0]  m_tdata;

	// bench copy of the deque
	logic [31:0]   held_value [DEPTH];
	logic [15:0]   held_wait  [DEPTH];
	logic [3:0]    front_slot = '0;
	int            held_count = 0;

	deque_view_t   pending_views [$];
	dir_row_t      dir_rows [$];
	int            fault_count = 0;
	bit            idling_on   = 1'b0;

	aging_double_ended_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one command to the bench deque and returns the view it reports.
	// Pushes at the front step the head back first; tick ages every held
	// entry and stops at all-ones. Full push and empty pop leave all as is.
	function automatic deque_view_t deque_apply(input logic [2:0] op,
			input logic [31:0] val);
		deque_view_t v;
		logic [3:0]  slot;
		v = '0;
		v.status = adq_pkg::ST_OK;
		case (op) inside
			adq_pkg::CMD_PUSH_FRONT, adq_pkg::CMD_PUSH_REAR: begin
				if (held_count >= DEPTH) begin
					v.status = adq_pkg::ST_OVER;
				end else begin
					if (op == adq_pkg::CMD_PUSH_FRONT) begin
						front_slot = front_slot - 4'd1;
						slot = front_slot;
					end else begin
						slot = front_slot + 4'(held_count);
					end
					held_value[slot] = val;
					held_wait[slot]  = '0;
					held_count++;
				end
			end
			adq_pkg::CMD_POP_FRONT, adq_pkg::CMD_POP_REAR: begin
				if (held_count == 0) begin
					v.status = adq_pkg::ST_UNDER;
				end else begin
					if (op == adq_pkg::CMD_POP_FRONT)
						front_slot = front_slot + 4'd1;
					held_count--;
				end
			end
			adq_pkg::CMD_TICK: begin
				for (int i = 0; i < held_count; i++) begin
					slot = front_slot + 4'(i);
					if (held_wait[slot] != '1)
						held_wait[slot] = held_wait[slot] + 16'd1;
				end
			end
			default: ;
		endcase
		v.entry_total = 5'(held_count);
		v.is_empty    = (held_count == 0);
		if (held_count != 0) begin
			slot = front_slot;
			v.front_value = held_value[slot];
			v.front_wait  = held_wait[slot];
			slot = front_slot + 4'(held_count - 1);
			v.rear_value  = held_value[slot];
			v.rear_wait   = held_wait[slot];
		end
		return v;
	endfunction

	function automatic deque_view_t mk_view(input adq_pkg::status_t st, input int total,
			input logic [31:0] fv, input int fw, input logic [31:0] rv, input int rw);
		deque_view_t v;
		v.status      = st;
		v.entry_total = 5'(total);
		v.is_empty    = (total == 0);
		v.front_value = fv;
		v.front_wait  = 16'(fw);
		v.rear_value  = rv;
		v.rear_wait   = 16'(rw);
		return v;
	endfunction

	task automatic add_row(input logic [2:0] op, input logic [31:0] val,
			input bit typed, input deque_view_t view);
		dir_row_t r;
		r.op    = op;
		r.val   = val;
		r.typed = typed;
		r.view  = view;
		dir_rows.push_back(r);
	endtask

	// Presents one command beat and holds it until taken. Must be entered
	// at a clock edge; returns at the edge where the beat was accepted.
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] val,
			input bit typed, input deque_view_t typed_view);
		deque_view_t v;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, val, op};
		do @(posedge clk); while (!s_tready);
		v = deque_apply(op, val);
		pending_views.push_back(typed ? typed_view : v);
	endtask

	task automatic sender_gap();
		if (idling_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// sender holds off until every outstanding result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	// lean: 0 fills, 1 drains, 2 balanced; ticks and spare codes mixed in
	function automatic logic [2:0] pick_cmd(input int lean);
		int r;
		int push_pct;
		r = $urandom_range(0, 99);
		push_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
		if (r < 3)
			return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		if (r < 23)
			return adq_pkg::CMD_TICK;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? adq_pkg::CMD_PUSH_FRONT : adq_pkg::CMD_PUSH_REAR;
		return $urandom_range(0, 1) ? adq_pkg::CMD_POP_FRONT : adq_pkg::CMD_POP_REAR;
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 7) != 0)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// result side: check each beat, then pick the ready level for next cycle
	initial begin
		deque_view_t got;
		deque_view_t want;
		int          stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = deque_view_t'(m_tdata);
				if (pending_views.size() == 0) begin
					fault_count++;
					if (fault_count <= SHOW_LIMIT)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					want = pending_views.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= SHOW_LIMIT)
							$display({"mismatch: status %0d/%0d total %0d/%0d",
								" empty %0d/%0d front %h,%0d / %h,%0d",
								" rear %h,%0d / %h,%0d (exp/got)"},
								want.status, got.status,
								want.entry_total, got.entry_total,
								want.is_empty, got.is_empty,
								want.front_value, want.front_wait,
								got.front_value, got.front_wait,
								want.rear_value, want.rear_wait,
								got.rear_value, got.rear_wait);
					end
				end
			end
			if (stall_left == 0 && idling_on && $urandom_range(0, 15) == 0)
				stall_left = $urandom_range(1, 15);
			m_tready <= (stall_left == 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL aging_double_ended_queue");
		$finish;
	end

	initial begin
		int lean;
		deque_view_t none;
		none = '0;

		// directed table: empty corner cases, extremes, fill to full, overflow
		add_row(adq_pkg::CMD_POP_FRONT, 32'h0000_0000, 1,
			mk_view(adq_pkg::ST_UNDER, 0, 0, 0, 0, 0));
		add_row(adq_pkg::CMD_POP_REAR, 32'h1234_5678, 1,
			mk_view(adq_pkg::ST_UNDER, 0, 0, 0, 0, 0));
		add_row(adq_pkg::CMD_TICK, 32'h0000_0000, 1,
			mk_view(adq_pkg::ST_OK, 0, 0, 0, 0, 0));
		add_row(CMD_SPARE_LO, 32'hdead_beef, 1,
			mk_view(adq_pkg::ST_OK, 0, 0, 0, 0, 0));
		// lone entry is both ends
		add_row(adq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1,
			mk_view(adq_pkg::ST_OK, 1, 32'h8000_0000, 0, 32'h8000_0000, 0));
		add_row(adq_pkg::CMD_TICK, 32'h0000_0000, 1,
			mk_view(adq_pkg::ST_OK, 1, 32'h8000_0000, 1, 32'h8000_0000, 1));
		add_row(adq_pkg::CMD_PUSH_REAR, 32'h7fff_ffff, 1,
			mk_view(adq_pkg::ST_OK, 2, 32'h8000_0000, 1, 32'h7fff_ffff, 0));
		add_row(adq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff, 1,
			mk_view(adq_pkg::ST_OK, 3, 32'hffff_ffff, 0, 32'h7fff_ffff, 0));
		add_row(CMD_SPARE_HI, 32'h0000_0000, 0, none);
		for (int i = 0; i < DEPTH - 3; i++)
			add_row((i % 2) ? adq_pkg::CMD_PUSH_REAR : adq_pkg::CMD_PUSH_FRONT,
				(i % 2) ? 32'h5555_5555 ^ 32'(i) : 32'haaaa_aaaa ^ 32'(i), 0, none);
		add_row(adq_pkg::CMD_PUSH_REAR, 32'h0bad_f00d, 0, none);   // full: overflow
		add_row(adq_pkg::CMD_POP_FRONT, 32'h0000_0000, 0, none);
		add_row(adq_pkg::CMD_POP_REAR, 32'h0000_0000, 0, none);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idling_on = 1'b1;
		foreach (dir_rows[k]) begin
			send_cmd(dir_rows[k].op, dir_rows[k].val, dir_rows[k].typed,
				dir_rows[k].view);
			sender_gap();
		end
		drain_results();

		// random traffic, lean re-chosen every 40 beats, idling by stretches
		lean = 2;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 40 == 0)
				lean = $urandom_range(0, 2);
			if (n % 100 == 0)
				idling_on = (n < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			send_cmd(pick_cmd(lean), pick_value(), 0, none);
			sender_gap();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && pending_views.size() == 0)
			$display("PASS aging_double_ended_queue");
		else
			$display("FAIL aging_double_ended_queue");
		$finish;
	end

endmodule
